// ----- src/rrap_pkg.sv -----
// ----------------------------------------------------------------------------
// rrap_pkg
// Shared widths, result codes and the result record of the request array
// parser.
// ----------------------------------------------------------------------------
package rrap_pkg;

  localparam int COUNT_BITS  = 21;
  localparam int LENGTH_BITS = 30;
  localparam int ERR_BITS    = 4;
  localparam int KIND_BITS   = 2;
  localparam int BYTE_BITS   = 8;

  // Width of the packed result data, rounded up to whole bytes
  localparam int OUT_FIELD_BITS = BYTE_BITS + COUNT_BITS + LENGTH_BITS + ERR_BITS;
  localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_PAD_BITS   = OUT_DATA_BITS - OUT_FIELD_BITS;

  localparam logic [COUNT_BITS-1:0]  COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [LENGTH_BITS-1:0] LEN_MAX   = {LENGTH_BITS{1'b1}};

  // Register indexes
  localparam logic CFG_MAX_ELEMENTS    = 1'b0;
  localparam logic CFG_MAX_BULK_LENGTH = 1'b1;

  // Reset values of the limit registers
  localparam logic [COUNT_BITS-1:0]  MAX_ELEMENTS_RST    = COUNT_BITS'(1048576);
  localparam logic [LENGTH_BITS-1:0] MAX_BULK_LENGTH_RST = LENGTH_BITS'(536870912);

  // Result kinds
  localparam logic [KIND_BITS-1:0] KIND_PAYLOAD  = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_TOKEN    = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_COMMAND  = 2'd2;
  localparam logic [KIND_BITS-1:0] KIND_ERROR    = 2'd3;

  // Error codes
  localparam logic [ERR_BITS-1:0] ERR_BAD_STAR    = 4'd0;
  localparam logic [ERR_BITS-1:0] ERR_BAD_COUNT   = 4'd1;
  localparam logic [ERR_BITS-1:0] ERR_COUNT_LIMIT = 4'd2;
  localparam logic [ERR_BITS-1:0] ERR_BAD_DOLLAR  = 4'd3;
  localparam logic [ERR_BITS-1:0] ERR_BAD_LENGTH  = 4'd4;
  localparam logic [ERR_BITS-1:0] ERR_LEN_LIMIT   = 4'd5;
  localparam logic [ERR_BITS-1:0] ERR_NO_CRLF     = 4'd6;
  localparam logic [ERR_BITS-1:0] ERR_TRUNCATED   = 4'd7;
  localparam logic [ERR_BITS-1:0] ERR_EMPTY_ARRAY = 4'd8;

  // Framing characters
  localparam logic [BYTE_BITS-1:0] CH_STAR   = 8'h2A;
  localparam logic [BYTE_BITS-1:0] CH_DOLLAR = 8'h24;
  localparam logic [BYTE_BITS-1:0] CH_CR     = 8'h0D;
  localparam logic [BYTE_BITS-1:0] CH_LF     = 8'h0A;
  localparam logic [BYTE_BITS-1:0] CH_ZERO   = 8'h30;
  localparam logic [BYTE_BITS-1:0] CH_NINE   = 8'h39;

  typedef struct packed {
    logic [KIND_BITS-1:0]   kind;
    logic [BYTE_BITS-1:0]   payload_byte;
    logic [COUNT_BITS-1:0]  token_index;
    logic [LENGTH_BITS-1:0] token_length;
    logic [ERR_BITS-1:0]    error_code;
    logic                   last;
  } result_t;

endpackage

// ----- src/resp_request_array_parser_top.sv -----
// ----------------------------------------------------------------------------
// resp_request_array_parser_top
// Byte-serial parser for a request framed as an array of bulk strings.
// ----------------------------------------------------------------------------
// One request byte is taken per clock. Each byte is parsed in the cycle it is
// accepted and yields zero, one or two result items, which are loaded into a
// two-entry output register and sent one per clock. A byte that yields at
// most one item is followed by the next byte in the next cycle as long as the
// item ahead of it is taken in that cycle; while that item is stalled the
// input is held. A byte that yields two items (the last token with its
// command report, or a payload byte or a token report with a truncation
// report) holds the input until the first is taken. Sustained rate is one
// byte per clock while the output is taken every cycle and no byte yields
// two items; the one item per clock of the output register sets it. Limit
// registers may be written at any time and take effect on the next byte.
module resp_request_array_parser_top
  import rrap_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  // configuration write port
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [LENGTH_BITS-1:0]   cfg_data,
  // request bytes
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [BYTE_BITS-1:0]     s_tdata,   // data_byte
  input  logic                     s_tlast,   // end_of_buffer
  // result items
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [OUT_DATA_BITS-1:0] m_tdata,   // payload_byte, token_index,
                                              // token_length, error_code, pad
  output logic [KIND_BITS-1:0]     m_tuser,   // kind
  output logic                     m_tlast    // last
);

  // Parse phases
  localparam logic [3:0] PH_IDLE     = 4'd0;
  localparam logic [3:0] PH_COUNT    = 4'd1;
  localparam logic [3:0] PH_COUNT_LF = 4'd2;
  localparam logic [3:0] PH_DOLLAR   = 4'd3;
  localparam logic [3:0] PH_LEN      = 4'd4;
  localparam logic [3:0] PH_LEN_LF   = 4'd5;
  localparam logic [3:0] PH_PAYLOAD  = 4'd6;
  localparam logic [3:0] PH_PAY_CR   = 4'd7;
  localparam logic [3:0] PH_PAY_LF   = 4'd8;
  localparam logic [3:0] PH_DRAIN    = 4'd9;

  logic [COUNT_BITS-1:0]  max_elements;
  logic [LENGTH_BITS-1:0] max_bulk_length;

  logic [3:0]             phase, phase_next;
  logic [LENGTH_BITS-1:0] acc, acc_next;
  logic                   digit_seen, digit_seen_next;
  logic [COUNT_BITS-1:0]  elems_left, elems_left_next;
  logic [COUNT_BITS-1:0]  cur_token, cur_token_next;
  logic [LENGTH_BITS-1:0] pay_left, pay_left_next;
  logic [LENGTH_BITS-1:0] cur_len, cur_len_next;

  result_t                buf0, buf1;
  logic [1:0]             cnt;

  logic                   in_fire, out_fire;
  logic                   is_digit;
  logic [LENGTH_BITS+3:0] acc_times_ten;
  logic [LENGTH_BITS-1:0] acc_digit;
  logic [LENGTH_BITS-1:0] max_elem_ext;
  logic [LENGTH_BITS-1:0] pay_dec;
  logic [COUNT_BITS-1:0]  elems_dec;

  logic                   first_v, cmd_v, err_v, trunc_v;
  result_t                first_res, cmd_res, err_res, trunc_res;
  logic [ERR_BITS-1:0]    err_code;
  result_t                slot0, slot1;
  logic [1:0]             n_res;

  assign out_fire = m_tvalid && m_tready;
  assign s_tready = (cnt == 2'd0) || ((cnt == 2'd1) && m_tready);
  assign in_fire  = s_tvalid && s_tready;

  // Saturating decimal accumulation
  assign is_digit      = (s_tdata >= CH_ZERO) && (s_tdata <= CH_NINE);
  assign acc_times_ten = ({4'b0, acc} << 3) + ({4'b0, acc} << 1)
                         + {{LENGTH_BITS{1'b0}}, s_tdata[3:0]};
  assign acc_digit     = (acc_times_ten > {4'b0, LEN_MAX}) ? LEN_MAX
                         : acc_times_ten[LENGTH_BITS-1:0];
  assign max_elem_ext  = {{(LENGTH_BITS-COUNT_BITS){1'b0}}, max_elements};
  assign pay_dec       = pay_left - LENGTH_BITS'(1);
  assign elems_dec     = elems_left - COUNT_BITS'(1);

  // Parse one byte: next state and the items it raises
  always_comb begin
    phase_next      = phase;
    acc_next        = acc;
    digit_seen_next = digit_seen;
    elems_left_next = elems_left;
    cur_token_next  = cur_token;
    pay_left_next   = pay_left;
    cur_len_next    = cur_len;
    first_v         = 1'b0;
    cmd_v           = 1'b0;
    err_v           = 1'b0;
    err_code        = ERR_BAD_STAR;
    first_res       = '0;
    cmd_res         = '0;

    unique case (phase)
      PH_IDLE: begin
        if (s_tdata == CH_STAR) begin
          acc_next        = '0;
          digit_seen_next = 1'b0;
          phase_next      = PH_COUNT;
        end else begin
          err_v    = 1'b1;
          err_code = ERR_BAD_STAR;
        end
      end
      PH_COUNT, PH_LEN: begin
        if (is_digit) begin
          acc_next        = acc_digit;
          digit_seen_next = 1'b1;
        end else if (s_tdata == CH_CR) begin
          phase_next = (phase == PH_COUNT) ? PH_COUNT_LF : PH_LEN_LF;
        end else begin
          err_v    = 1'b1;
          err_code = (phase == PH_COUNT) ? ERR_BAD_COUNT : ERR_BAD_LENGTH;
        end
      end
      PH_COUNT_LF: begin
        err_v = 1'b1;
        if (s_tdata != CH_LF) begin
          err_code = ERR_NO_CRLF;
        end else if (!digit_seen) begin
          err_code = ERR_BAD_COUNT;
        end else if ((acc == LEN_MAX) || (acc > max_elem_ext)
                     || (acc[LENGTH_BITS-1:COUNT_BITS] != '0)) begin
          err_code = ERR_COUNT_LIMIT;
        end else if (acc == '0) begin
          err_code = ERR_EMPTY_ARRAY;
        end else begin
          err_v           = 1'b0;
          elems_left_next = acc[COUNT_BITS-1:0];
          cur_token_next  = '0;
          phase_next      = PH_DOLLAR;
        end
      end
      PH_DOLLAR: begin
        if (s_tdata == CH_DOLLAR) begin
          acc_next        = '0;
          digit_seen_next = 1'b0;
          phase_next      = PH_LEN;
        end else begin
          err_v    = 1'b1;
          err_code = ERR_BAD_DOLLAR;
        end
      end
      PH_LEN_LF: begin
        err_v = 1'b1;
        if (s_tdata != CH_LF) begin
          err_code = ERR_NO_CRLF;
        end else if (!digit_seen) begin
          err_code = ERR_BAD_LENGTH;
        end else if ((acc == LEN_MAX) || (acc > max_bulk_length)) begin
          err_code = ERR_LEN_LIMIT;
        end else begin
          err_v         = 1'b0;
          cur_len_next  = acc;
          pay_left_next = acc;
          phase_next    = (acc != '0) ? PH_PAYLOAD : PH_PAY_CR;
        end
      end
      PH_PAYLOAD: begin
        first_v                = 1'b1;
        first_res.kind         = KIND_PAYLOAD;
        first_res.payload_byte = s_tdata;
        first_res.token_index  = cur_token;
        pay_left_next          = pay_dec;
        if (pay_dec == '0) begin
          phase_next = PH_PAY_CR;
        end
      end
      PH_PAY_CR: begin
        if (s_tdata == CH_CR) begin
          phase_next = PH_PAY_LF;
        end else begin
          err_v    = 1'b1;
          err_code = ERR_NO_CRLF;
        end
      end
      PH_PAY_LF: begin
        if (s_tdata != CH_LF) begin
          err_v    = 1'b1;
          err_code = ERR_NO_CRLF;
        end else begin
          first_v                = 1'b1;
          first_res.kind         = KIND_TOKEN;
          first_res.token_index  = cur_token;
          first_res.token_length = cur_len;
          elems_left_next        = elems_dec;
          if (elems_dec == '0) begin
            cmd_v               = 1'b1;
            cmd_res.kind        = KIND_COMMAND;
            cmd_res.token_index = cur_token;
            phase_next          = PH_DRAIN;
          end else begin
            cur_token_next = cur_token + COUNT_BITS'(1);
            phase_next     = PH_DOLLAR;
          end
        end
      end
      default: begin
      end
    endcase

    if (err_v) begin
      phase_next = PH_DRAIN;
    end

    // End mark: report truncation if unfinished, then return to idle
    trunc_v = s_tlast && (phase_next != PH_DRAIN);
    if (s_tlast) begin
      phase_next      = PH_IDLE;
      acc_next        = '0;
      digit_seen_next = 1'b0;
      elems_left_next = '0;
      cur_token_next  = '0;
      pay_left_next   = '0;
      cur_len_next    = '0;
    end
  end

  // Pack the raised items into two slots in order
  always_comb begin
    err_res              = '0;
    err_res.kind         = KIND_ERROR;
    err_res.error_code   = err_code;
    trunc_res            = '0;
    trunc_res.kind       = KIND_ERROR;
    trunc_res.error_code = ERR_TRUNCATED;

    n_res = 2'({1'b0, first_v} + {1'b0, cmd_v} + {1'b0, err_v} + {1'b0, trunc_v});

    if (first_v) begin
      slot0 = first_res;
    end else if (err_v) begin
      slot0 = err_res;
    end else begin
      slot0 = trunc_res;
    end
    slot1 = cmd_v ? cmd_res : trunc_res;

    slot0.last = (n_res == 2'd1);
    slot1.last = 1'b1;
  end

  // Limit registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_elements    <= MAX_ELEMENTS_RST;
      max_bulk_length <= MAX_BULK_LENGTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_ELEMENTS:    max_elements    <= cfg_data[COUNT_BITS-1:0];
        CFG_MAX_BULK_LENGTH: max_bulk_length <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Parser state: advance on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      acc        <= '0;
      digit_seen <= 1'b0;
      elems_left <= '0;
      cur_token  <= '0;
      pay_left   <= '0;
      cur_len    <= '0;
    end else if (in_fire) begin
      phase      <= phase_next;
      acc        <= acc_next;
      digit_seen <= digit_seen_next;
      elems_left <= elems_left_next;
      cur_token  <= cur_token_next;
      pay_left   <= pay_left_next;
      cur_len    <= cur_len_next;
    end
  end

  // Output register: load on accept, shift on send
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (in_fire) begin
      cnt <= n_res;
    end else if (out_fire) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      buf0 <= slot0;
      buf1 <= slot1;
    end else if (out_fire) begin
      buf0 <= buf1;
    end
  end

  assign m_tvalid = (cnt != 2'd0);
  assign m_tuser  = buf0.kind;
  assign m_tlast  = buf0.last;
  assign m_tdata  = {{OUT_PAD_BITS{1'b0}}, buf0.error_code, buf0.token_length,
                     buf0.token_index, buf0.payload_byte};

  // Checks
  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("output register holds more than two items");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    cnt == 2'd2 |-> !buf0.last && buf1.last)
    else $error("first of two pending items carries the last flag");

  a_eob_idle: assert property (@(posedge clk) disable iff (rst)
    in_fire && s_tlast |=> phase == PH_IDLE && acc == '0 && cur_token == '0)
    else $error("end mark did not return the parser to idle");

  a_payload_left: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> pay_left != '0)
    else $error("payload phase with no bytes left");

endmodule
